### design/rtt_pkg.sv
// Shared types and constants for the repeating timer table.
package rtt_pkg;

   localparam int TIMER_SLOTS_DEF = 8;

   localparam int OP_W       = 3;
   localparam int KEY_W      = 16;
   localparam int IVAL_W     = 32;
   localparam int CNT_W      = 16;
   localparam int TIME_W     = 32;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 24;

   // req_tdata field positions
   localparam int KEY_LO   = 0;
   localparam int IVAL_LO  = KEY_LO + KEY_W;
   localparam int CNT_LO   = IVAL_LO + IVAL_W;
   localparam int MICRO_LO = CNT_LO + CNT_W;
   localparam int US_LO    = MICRO_LO + 1;
   localparam int MS_LO    = US_LO + TIME_W;

   localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET   = 3'd1;
   localparam logic [OP_W-1:0] OP_KILL  = 3'd2;
   localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

   localparam logic KIND_FIRED  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [IVAL_W-1:0] interval;
      logic [CNT_W-1:0]  remaining;
      logic [TIME_W-1:0] stamp;
      logic              micro;
   } slot_type;

   typedef struct packed {
      logic load;
      logic idx_clear;
      logic idx_next;
      logic fire;
      logic free;
      logic insert;
      logic flush;
      logic seek_hit;
      logic seek_end;
      logic emit;
      logic kind;
      logic ok;
   } rtt_cmd_type;

   typedef struct packed {
      logic in_range;
      logic idx_act;
      logic idx_top;
      logic key_zero;
      logic hw_full;
      logic key_match;
      logic due;
      logic out_busy;
   } rtt_status_type;

endpackage

### design/repeating_timer_table.sv
// Top level of the repeating timer table.
//
// One word is handled at a time. The slot table sits in a RAM read one slot
// per cycle, so a tick or a key search walks the slots below the high-water
// mark: the word is accepted and decoded, then each slot is read, an
// occupied slot is also evaluated and a due one fired, the end of the scan
// is found unless a key search stops on a match, and the status word is sent.
// A set that succeeds then writes the slot and searches upward for the next
// free one. Flush and unknown opcodes go straight from decode to the status
// word. A stalled result side holds the sequencer only when a second result
// is ready while the first still waits. The table needs no clearing pass
// after reset.
module repeating_timer_table #(
   parameter int TIMER_SLOTS = rtt_pkg::TIMER_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // timer_key, interval, repeat_count, micro_base, now_us, now_ms, zero pad
   input  logic [rtt_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [rtt_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // fired_key, ok, zero pad
   output logic [rtt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import rtt_pkg::*;

   rtt_cmd_type    cmd;
   rtt_status_type status;

   rtt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   rtt_dp #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/rtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rtt_dp.sv
// Datapath: slot store, occupancy bookkeeping, scan index and result register.
module rtt_dp #(
   parameter int TIMER_SLOTS = rtt_pkg::TIMER_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rtt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  rtt_pkg::rtt_cmd_type           cmd,
   output rtt_pkg::rtt_status_type        status,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rtt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import rtt_pkg::*;

   localparam int AW = $clog2(TIMER_SLOTS);
   localparam int HW = $clog2(TIMER_SLOTS + 1);

   // latched word
   logic [KEY_W-1:0]  key_ff;
   logic [IVAL_W-1:0] ival_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              micro_ff;
   logic [TIME_W-1:0] now_us_ff;
   logic [TIME_W-1:0] now_ms_ff;

   logic [TIMER_SLOTS-1:0] active_ff, active_in;
   logic [HW-1:0]          hw_ff, hw_in;
   logic [AW-1:0]          lowfree_ff, lowfree_in;
   logic [HW-1:0]          idx_ff, idx_in;
   logic [AW-1:0]          idx_a;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0] rsp_key_ff;
   logic             rsp_ok_ff;
   logic             rsp_kind_ff;

   slot_type          rd_slot;
   slot_type          wr_slot;
   logic [$bits(slot_type)-1:0] rd_word;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [TIME_W-1:0] now_sel;
   logic [TIME_W-1:0] elapsed;
   logic              do_free;

   assign idx_a   = idx_ff[AW-1:0];
   assign rd_slot = slot_type'(rd_word);

   rtt_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (TIMER_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (idx_a),
      .rd_data (rd_word)
   );

   assign now_sel = rd_slot.micro ? now_us_ff : now_ms_ff;
   assign elapsed = now_sel - rd_slot.stamp;
   assign do_free = cmd.free || (cmd.fire && rd_slot.remaining == CNT_W'(1));

   always_comb begin
      wr_en   = cmd.fire || cmd.insert;
      wr_addr = cmd.insert ? lowfree_ff : idx_a;
      if (cmd.insert) begin
         wr_slot.key       = key_ff;
         wr_slot.interval  = ival_ff;
         wr_slot.remaining = cnt_ff;
         wr_slot.stamp     = micro_ff ? now_us_ff : now_ms_ff;
         wr_slot.micro     = micro_ff;
      end else begin
         wr_slot       = rd_slot;
         wr_slot.stamp = now_sel;
         if (rd_slot.remaining > CNT_W'(1)) begin
            wr_slot.remaining = rd_slot.remaining - CNT_W'(1);
         end
      end
   end

   always_comb begin
      active_in  = active_ff;
      hw_in      = hw_ff;
      lowfree_in = lowfree_ff;
      idx_in     = idx_ff;
      if (cmd.flush) begin
         active_in  = '0;
         hw_in      = '0;
         lowfree_in = '0;
      end
      if (do_free) begin
         active_in[idx_a] = 1'b0;
         if (idx_a < lowfree_ff) begin
            lowfree_in = idx_a;
         end
         if (idx_ff == hw_ff - HW'(1)) begin
            hw_in = hw_ff - HW'(1);
         end
      end
      if (cmd.insert) begin
         active_in[lowfree_ff] = 1'b1;
         if (HW'(lowfree_ff) >= hw_ff) begin
            hw_in = HW'(lowfree_ff) + HW'(1);
         end
      end
      if (cmd.seek_hit) begin
         lowfree_in = idx_a;
      end
      if (cmd.seek_end) begin
         lowfree_in = AW'(TIMER_SLOTS - 1);
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.insert) begin
         idx_in = HW'(lowfree_ff) + HW'(1);
      end else if (cmd.idx_next) begin
         idx_in = idx_ff + HW'(1);
      end
   end

   always_comb begin
      status.in_range  = idx_ff < hw_ff;
      status.idx_top   = idx_ff >= HW'(TIMER_SLOTS);
      status.idx_act   = !status.idx_top && active_ff[idx_a];
      status.key_zero  = key_ff == '0;
      status.hw_full   = hw_ff == HW'(TIMER_SLOTS);
      status.key_match = rd_slot.key == key_ff;
      status.due       = elapsed >= rd_slot.interval;
      status.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         hw_ff        <= '0;
         lowfree_ff   <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         hw_ff        <= hw_in;
         lowfree_ff   <= lowfree_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff    <= req_tdata[KEY_LO +: KEY_W];
         ival_ff   <= req_tdata[IVAL_LO +: IVAL_W];
         cnt_ff    <= req_tdata[CNT_LO +: CNT_W];
         micro_ff  <= req_tdata[MICRO_LO];
         now_us_ff <= req_tdata[US_LO +: TIME_W];
         now_ms_ff <= req_tdata[MS_LO +: TIME_W];
      end
      if (cmd.emit) begin
         rsp_key_ff  <= (cmd.kind == KIND_FIRED) ? rd_slot.key : '0;
         rsp_ok_ff   <= cmd.ok;
         rsp_kind_ff <= cmd.kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ok_ff, rsp_key_ff});
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_kind_ff == KIND_STATUS;

endmodule

### design/rtt_ctrl.sv
// Controller: sequences one operation at a time over the slot datapath.
module rtt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [rtt_pkg::OP_W-1:0] req_tuser,
   input  rtt_pkg::rtt_status_type  status,
   output rtt_pkg::rtt_cmd_type     cmd
);
   import rtt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_EVAL,
      S_FIRE,
      S_INSERT,
      S_SEEK,
      S_STATUS
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic              ok_ff, ok_in;

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      ok_in    = ok_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load      = 1'b1;
               cmd.idx_clear = 1'b1;
               op_in         = req_tuser;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_STATUS;
            case (op_ff)
               OP_TICK: begin
                  state_in = S_READ;
               end
               OP_SET: begin
                  ok_in = 1'b0;
                  if (!status.key_zero && !status.hw_full) begin
                     state_in = S_READ;
                  end
               end
               OP_KILL: begin
                  ok_in = 1'b1;
                  if (!status.key_zero) begin
                     state_in = S_READ;
                  end
               end
               OP_QUERY: begin
                  ok_in = 1'b0;
                  if (!status.key_zero) begin
                     state_in = S_READ;
                  end
               end
               OP_FLUSH: begin
                  cmd.flush = 1'b1;
                  ok_in     = 1'b1;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         S_READ: begin
            if (!status.in_range) begin
               case (op_ff)
                  OP_SET: begin
                     state_in = S_INSERT;
                  end
                  OP_QUERY: begin
                     ok_in    = 1'b0;
                     state_in = S_STATUS;
                  end
                  default: begin
                     ok_in    = 1'b1;
                     state_in = S_STATUS;
                  end
               endcase
            end else if (!status.idx_act) begin
               cmd.idx_next = 1'b1;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (op_ff == OP_TICK) begin
               if (status.due) begin
                  state_in = S_FIRE;
               end else begin
                  cmd.idx_next = 1'b1;
                  state_in     = S_READ;
               end
            end else if (status.key_match) begin
               state_in = S_STATUS;
               case (op_ff)
                  OP_SET: begin
                     ok_in = 1'b0;
                  end
                  OP_KILL: begin
                     cmd.free = 1'b1;
                     ok_in    = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b1;
                  end
               endcase
            end else begin
               cmd.idx_next = 1'b1;
               state_in     = S_READ;
            end
         end
         S_FIRE: begin
            if (!status.out_busy) begin
               cmd.fire     = 1'b1;
               cmd.emit     = 1'b1;
               cmd.kind     = KIND_FIRED;
               cmd.ok       = 1'b1;
               cmd.idx_next = 1'b1;
               state_in     = S_READ;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            ok_in      = 1'b1;
            state_in   = S_SEEK;
         end
         S_SEEK: begin
            if (status.idx_top) begin
               cmd.seek_end = 1'b1;
               state_in     = S_STATUS;
            end else if (!status.idx_act) begin
               cmd.seek_hit = 1'b1;
               state_in     = S_STATUS;
            end else begin
               cmd.idx_next = 1'b1;
            end
         end
         S_STATUS: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_STATUS;
               cmd.ok   = ok_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_TICK;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         ok_ff    <= ok_in;
      end
   end

endmodule

### tb/repeating_timer_table_test.sv
// Self-checking testbench for the repeating timer table.
`timescale 1ns / 1ps

module repeating_timer_table_test;
   import rtt_pkg::*;

   localparam int SLOTS = TIMER_SLOTS_DEF;
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      logic [IVAL_W-1:0] ival;
      logic [CNT_W-1:0]  cnt;
      logic              micro;
      logic [TIME_W-1:0] now_us;
      logic [TIME_W-1:0] now_ms;
   } timer_cmd_type;

   typedef struct {
      logic             kind;
      logic [KEY_W-1:0] key;
      logic             ok;
      logic             last;
   } timer_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   repeating_timer_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   timer_cmd_type  command_queue[$];
   timer_word_type awaited_words[$];
   timer_cmd_type  in_flight;
   int words_sent = 0;
   int total_cmds = 0;
   int failures = 0;
   int cycle_count = 0;
   logic calm;

   logic [TIME_W-1:0] cur_us = 32'hFFFF_FFF8;
   logic [TIME_W-1:0] cur_ms = 32'hFFFF_FFFE;

   // shadow copy of the slot table
   logic              slot_on[SLOTS];
   logic [KEY_W-1:0]  slot_id[SLOTS];
   logic [IVAL_W-1:0] slot_period[SLOTS];
   logic [CNT_W-1:0]  slot_left[SLOTS];
   logic [TIME_W-1:0] slot_last[SLOTS];
   logic              slot_us[SLOTS];
   int top_used;
   int first_free;

   assign calm = (words_sent >= 40) && (words_sent < 80);

   initial begin
      forever #4 clock = ~clock;
   end

   task clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         slot_on[i] = 1'b0;
         slot_id[i] = '0;
         slot_period[i] = '0;
         slot_left[i] = '0;
         slot_last[i] = '0;
         slot_us[i] = 1'b0;
      end
      top_used = -1;
      first_free = 0;
   endtask

   task release_slot(input int i);
      if (i < first_free) first_free = i;
      if (i == top_used) top_used = top_used - 1;
      slot_on[i] = 1'b0;
      slot_id[i] = '0;
   endtask

   function automatic logic key_running(input logic [KEY_W-1:0] key);
      logic found;
      found = 1'b0;
      if (key != '0) begin
         for (int j = 0; j <= top_used && j < SLOTS; j++)
            if (slot_on[j] && slot_id[j] == key) found = 1'b1;
      end
      return found;
   endfunction

   task push_word(input logic kind, input logic [KEY_W-1:0] key, input logic ok,
                  input logic last);
      timer_word_type w;
      w.kind = kind;
      w.key = key;
      w.ok = ok;
      w.last = last;
      awaited_words.push_back(w);
   endtask

   task apply_command(input timer_cmd_type c);
      logic [TIME_W-1:0] now;
      logic accept;
      logic hit;
      int s;
      case (c.op)
         OP_TICK: begin
            for (int i = 0; i <= top_used && i < SLOTS; i++) begin
               if (slot_on[i]) begin
                  now = slot_us[i] ? c.now_us : c.now_ms;
                  if (now - slot_last[i] >= slot_period[i]) begin
                     slot_last[i] = now;
                     push_word(KIND_FIRED, slot_id[i], 1'b1, 1'b0);
                     if (slot_left[i] == 1) release_slot(i);
                     else if (slot_left[i] > 1) slot_left[i] = slot_left[i] - 1'b1;
                  end
               end
            end
            push_word(KIND_STATUS, '0, 1'b1, 1'b1);
         end
         OP_SET: begin
            accept = (c.key != '0) && (top_used < SLOTS - 1) && !key_running(c.key);
            if (accept) begin
               s = first_free;
               slot_period[s] = c.ival;
               slot_left[s] = c.cnt;
               slot_id[s] = c.key;
               slot_us[s] = c.micro;
               slot_last[s] = c.micro ? c.now_us : c.now_ms;
               slot_on[s] = 1'b1;
               if (top_used < s) top_used = s;
               hit = 1'b0;
               for (int j = first_free; j < SLOTS; j++) begin
                  if (!hit && !slot_on[j]) begin
                     first_free = j;
                     hit = 1'b1;
                  end
               end
               if (!hit) first_free = SLOTS - 1;
            end
            push_word(KIND_STATUS, '0, accept, 1'b1);
         end
         OP_KILL: begin
            hit = 1'b0;
            if (c.key != '0) begin
               for (int i = 0; i <= top_used && i < SLOTS; i++) begin
                  if (!hit && slot_on[i] && slot_id[i] == c.key) begin
                     release_slot(i);
                     hit = 1'b1;
                  end
               end
            end
            push_word(KIND_STATUS, '0, 1'b1, 1'b1);
         end
         OP_FLUSH: begin
            clear_table();
            push_word(KIND_STATUS, '0, 1'b1, 1'b1);
         end
         OP_QUERY: push_word(KIND_STATUS, '0, key_running(c.key), 1'b1);
         default: push_word(KIND_STATUS, '0, 1'b0, 1'b1);
      endcase
   endtask

   task post(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
             input logic [IVAL_W-1:0] ival, input logic [CNT_W-1:0] cnt, input logic micro);
      timer_cmd_type c;
      c.op = op;
      c.key = key;
      c.ival = ival;
      c.cnt = cnt;
      c.micro = micro;
      c.now_us = cur_us;
      c.now_ms = cur_ms;
      command_queue.push_back(c);
   endtask

   // driver
   always @(posedge clock) begin : drive
      logic gap;
      logic [REQ_DATA_W-1:0] d;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_command(in_flight);
            words_sent <= words_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            gap = !calm && ($urandom_range(0, 99) < 6);
            if (command_queue.size() != 0 && !gap) begin
               in_flight = command_queue.pop_front();
               d = '0;
               d[KEY_LO +: KEY_W] = in_flight.key;
               d[IVAL_LO +: IVAL_W] = in_flight.ival;
               d[CNT_LO +: CNT_W] = in_flight.cnt;
               d[MICRO_LO] = in_flight.micro;
               d[US_LO +: TIME_W] = in_flight.now_us;
               d[MS_LO +: TIME_W] = in_flight.now_ms;
               req_tvalid <= 1'b1;
               req_tdata <= d;
               req_tuser <= in_flight.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      timer_word_type w;
      logic [KEY_W-1:0] got_key;
      logic got_ok;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_key = rsp_tdata[KEY_W-1:0];
            got_ok = rsp_tdata[KEY_W];
            if (awaited_words.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected word: kind %0d key %h ok %0d last %0d",
                           rsp_tuser, got_key, got_ok, rsp_tlast);
            end else begin
               w = awaited_words.pop_front();
               if (rsp_tuser !== w.kind || got_key !== w.key || got_ok !== w.ok ||
                   rsp_tlast !== w.last) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch: exp kind %0d key %h ok %0d last %0d, ",
                               "got kind %0d key %h ok %0d last %0d"},
                              w.kind, w.key, w.ok, w.last, rsp_tuser, got_key, got_ok,
                              rsp_tlast);
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 6);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : main
      int pick;
      logic [OP_W-1:0] op;
      logic [KEY_W-1:0] key;
      logic [IVAL_W-1:0] ival;
      logic [CNT_W-1:0] cnt;
      clear_table();

      // directed: key 0 cases, empty table, duplicates, full table, stale mark
      post(OP_QUERY, '0, '0, '0, 1'b0);
      post(OP_KILL, '0, '0, '0, 1'b0);
      post(OP_KILL, 16'h0005, '0, '0, 1'b0);
      post(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      post(OP_SET, '0, 32'd10, 16'd1, 1'b1);
      post(OP_SET, 16'hFFFF, '0, '0, 1'b1);
      post(OP_SET, 16'd1, 32'hFFFF_FFFF, 16'd1, 1'b0);
      post(OP_SET, 16'd1, 32'd3, 16'd3, 1'b1);
      post(OP_SET, 16'd2, 32'd5, 16'd2, 1'b1);
      cur_us = cur_us + 32'd10;
      cur_ms = cur_ms - 32'd1;
      post(OP_TICK, '0, '0, '0, 1'b0);
      cur_us = cur_us + 32'd5;
      post(OP_TICK, '0, '0, '0, 1'b0);
      for (int k = 3; k <= 9; k++)
         post(OP_SET, KEY_W'(k), 32'h8000_0000, 16'hFFFF, k[0]);
      post(OP_SET, 16'd10, 32'd1, 16'd1, 1'b1);
      post(OP_KILL, 16'd3, '0, '0, 1'b0);
      post(OP_SET, 16'd10, 32'd1, 16'd1, 1'b1);
      post(OP_KILL, 16'd9, '0, '0, 1'b0);
      post(OP_SET, 16'd10, 32'd1, 16'd0, 1'b1);
      post(OP_QUERY, 16'd10, '0, '0, 1'b0);
      cur_us = cur_us + 32'h9000_0000;
      cur_ms = cur_ms + 32'h9000_0000;
      post(OP_TICK, '0, '0, '0, 1'b0);
      post(OP_UNUSED_FIRST, 16'd10, '0, '0, 1'b0);
      post(OP_UNUSED_LAST, '0, '0, '0, 1'b0);
      post(OP_FLUSH, '0, '0, '0, 1'b0);
      post(OP_QUERY, 16'd4, '0, '0, 1'b0);

      for (int n = 0; n < 81; n++) begin
         cur_us = cur_us + 32'($urandom_range(0, 12));
         cur_ms = cur_ms + 32'($urandom_range(0, 8));
         if ($urandom_range(0, 99) < 3) begin
            cur_us = $urandom;
            cur_ms = $urandom;
         end
         if ($urandom_range(0, 99) < 4) key = '0;
         else if ($urandom_range(0, 19) == 0) key = KEY_W'($urandom);
         else key = KEY_W'($urandom_range(1, 12));
         ival = ($urandom_range(0, 19) == 0) ? $urandom : IVAL_W'($urandom_range(0, 40));
         cnt = ($urandom_range(0, 19) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 4));
         pick = $urandom_range(0, 99);
         if (pick < 38) op = OP_TICK;
         else if (pick < 66) op = OP_SET;
         else if (pick < 79) op = OP_KILL;
         else if (pick < 92) op = OP_QUERY;
         else if (pick < 95) op = OP_FLUSH;
         else op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
         post(op, key, ival, cnt, 1'($urandom_range(0, 1)));
      end
      total_cmds = command_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (words_sent != total_cmds || awaited_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && awaited_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
